>>> sv/gql_pkg.sv
// ----------------------------------------------------------------------------
// gql_pkg
// shared types, constants and fixed point helpers of the glyph quad layout
// ----------------------------------------------------------------------------
package gql_pkg;

   localparam int GLYPH_COUNT_DEFAULT = 128;

   localparam int COORD_W   = 24;
   localparam int UV_W      = 17;
   localparam int PROD_W    = 48;
   localparam int RND_W     = 36;
   localparam int SUM_W     = 40;
   localparam int FRAC_DROP = 8;

   localparam logic [7:0] CH_NEWLINE  = 8'd10;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_QUESTION = 8'd63;

   localparam logic OP_LOAD = 1'b0;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(128);
   localparam logic signed [SUM_W-1:0]  UV_ONE     = SUM_W'(65536);
   localparam logic signed [SUM_W-1:0]  COORD_MAX  = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0]  COORD_MIN  = SUM_W'(-8388608);

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_NEWLINE,
      KIND_SPACE,
      KIND_GLYPH
   } kind_type;

   typedef struct packed {
      logic [11:0]       atlas_x;
      logic [11:0]       atlas_y;
      logic [7:0]        glyph_w;
      logic [7:0]        glyph_h;
      logic signed [7:0] bearing_x;
      logic signed [7:0] bearing_y;
      logic [7:0]        advance_w;
      logic [7:0]        cell_h;
   } glyph_rec_type;

   typedef struct packed {
      logic [31:0] x_step;
      logic [31:0] y_step;
      logic [24:0] tex_u_step;
      logic [24:0] tex_v_step;
   } step_cfg_type;

   typedef struct packed {
      kind_type kind;
      logic     start;
   } item_ctl_type;

   typedef struct packed {
      item_ctl_type             ctl;
      logic signed [RND_W-1:0]  bear_x;
      logic signed [RND_W-1:0]  width_x;
      logic signed [RND_W-1:0]  off_y;
      logic signed [RND_W-1:0]  height_y;
      logic signed [RND_W-1:0]  adv_x;
      logic signed [RND_W-1:0]  u_left;
      logic signed [RND_W-1:0]  u_width;
      logic signed [RND_W-1:0]  v_top;
      logic signed [RND_W-1:0]  v_height;
   } scaled_type;

   typedef struct packed {
      logic advance;
      logic capture;
   } pen_ctl_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_left;
      logic signed [COORD_W-1:0] pos_right;
      logic signed [COORD_W-1:0] pos_top;
      logic signed [COORD_W-1:0] pos_bottom;
      logic [UV_W-1:0]           uv_left;
      logic [UV_W-1:0]           uv_right;
      logic [UV_W-1:0]           uv_top_flip;
      logic [UV_W-1:0]           uv_bottom_flip;
   } quad_type;

   // q.24 product to q.16, round half up
   function automatic logic signed [RND_W-1:0] round_step(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0] biased;
      biased = prod + ROUND_HALF;
      return RND_W'(biased >>> FRAC_DROP);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      if (v > COORD_MAX) begin
         return COORD_W'(COORD_MAX);
      end
      if (v < COORD_MIN) begin
         return COORD_W'(COORD_MIN);
      end
      return COORD_W'(v);
   endfunction

   function automatic logic [UV_W-1:0] sat_uv(input logic signed [SUM_W-1:0] v);
      if (v > UV_ONE) begin
         return UV_W'(UV_ONE);
      end
      if (v < 0) begin
         return '0;
      end
      return UV_W'(v);
   endfunction

endpackage

>>> sv/glyph_quad_layout_core.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_core
// bitmap font glyph quad layout: glyph table, pen tracking and quad output
// ----------------------------------------------------------------------------
// one item per clock sustained on req unless a held response stalls the
// second stage; the glyph table single read port sits in the first stage,
// the multipliers in the second and the pen add with saturation in the last,
// so a character can follow a glyph load or another character in the very
// next cycle; the table reads as all zero after reset through per-entry
// valid bits, with no clearing pass; newline and space move the pen using
// the space glyph and give no result, loads give no result
module glyph_quad_layout_core #(
   parameter int GLYPH_COUNT = gql_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // code, atlas_x, atlas_y, glyph_w, glyph_h, bearing_x, bearing_y, advance_w,
   // cell_h, start_of_text, zero fill
   input  logic [87:0]  req_tdata,
   // op
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_left, pos_right, pos_top, pos_bottom, uv_left, uv_right, uv_top_flip,
   // uv_bottom_flip, zero fill
   output logic [167:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int ADDR_W = $clog2(GLYPH_COUNT);

   localparam logic [2:0] CSR_X_STEP     = 3'd0;
   localparam logic [2:0] CSR_Y_STEP     = 3'd1;
   localparam logic [2:0] CSR_TEX_U_STEP = 3'd2;
   localparam logic [2:0] CSR_TEX_V_STEP = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_X   = 3'd4;
   localparam logic [2:0] CSR_ORIGIN_Y   = 3'd5;

   gql_pkg::step_cfg_type              steps_ff;
   logic signed [gql_pkg::COORD_W-1:0] origin_x_ff;
   logic signed [gql_pkg::COORD_W-1:0] origin_y_ff;

   gql_pkg::glyph_rec_type in_rec;
   gql_pkg::item_ctl_type  in_ctl;
   logic [7:0]             in_code;
   logic                   in_range;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic                   accept;

   gql_pkg::item_ctl_type  s1_ctl_ff;
   logic                   v1_ff;
   logic                   v2_ff;
   logic                   rsp_valid_ff;
   gql_pkg::glyph_rec_type s1_rec;
   gql_pkg::scaled_type    s2;
   gql_pkg::pen_ctl_type   pen_ctl;
   gql_pkg::quad_type      quad;

   logic res2;
   logic out_free;
   logic move2;
   logic free2;
   logic free1;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff    <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_X_STEP:     steps_ff.x_step     <= csr_data;
            CSR_Y_STEP:     steps_ff.y_step     <= csr_data;
            CSR_TEX_U_STEP: steps_ff.tex_u_step <= csr_data[24:0];
            CSR_TEX_V_STEP: steps_ff.tex_v_step <= csr_data[24:0];
            CSR_ORIGIN_X:   origin_x_ff         <= csr_data[23:0];
            CSR_ORIGIN_Y:   origin_y_ff         <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // request decode
   always_comb begin
      in_code          = req_tdata[7:0];
      in_rec.atlas_x   = req_tdata[19:8];
      in_rec.atlas_y   = req_tdata[31:20];
      in_rec.glyph_w   = req_tdata[39:32];
      in_rec.glyph_h   = req_tdata[47:40];
      in_rec.bearing_x = req_tdata[55:48];
      in_rec.bearing_y = req_tdata[63:56];
      in_rec.advance_w = req_tdata[71:64];
      in_rec.cell_h    = req_tdata[79:72];
      in_ctl.start     = req_tdata[80];
      in_range         = {24'd0, in_code} < 32'(GLYPH_COUNT);

      if (req_tuser[0] == gql_pkg::OP_LOAD) begin
         in_ctl.kind = gql_pkg::KIND_LOAD;
      end else if (in_code == gql_pkg::CH_NEWLINE) begin
         in_ctl.kind = gql_pkg::KIND_NEWLINE;
      end else if (in_code == gql_pkg::CH_SPACE) begin
         in_ctl.kind = gql_pkg::KIND_SPACE;
      end else begin
         in_ctl.kind = gql_pkg::KIND_GLYPH;
      end

      unique case (in_ctl.kind) inside
         gql_pkg::KIND_NEWLINE, gql_pkg::KIND_SPACE: rd_addr = ADDR_W'(gql_pkg::CH_SPACE);
         gql_pkg::KIND_GLYPH: rd_addr = in_range ? ADDR_W'(in_code)
                                                 : ADDR_W'(gql_pkg::CH_QUESTION);
         default: rd_addr = '0;
      endcase
   end

   // pipeline flow, empty or drained stages take the next item
   assign res2     = s2.ctl.kind == gql_pkg::KIND_GLYPH;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign move2    = v2_ff && (out_free || !res2);
   assign free2    = !v2_ff || move2;
   assign free1    = !v1_ff || free2;
   assign accept   = req_tvalid && free1;
   assign wr_en    = accept && (req_tuser[0] == gql_pkg::OP_LOAD) && in_range;

   assign pen_ctl.advance = move2;
   assign pen_ctl.capture = move2 && res2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (free1) begin
            v1_ff <= req_tvalid;
         end
         if (free2) begin
            v2_ff <= v1_ff;
         end
         if (pen_ctl.capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free1) begin
         s1_ctl_ff <= in_ctl;
      end
   end

   gql_glyph_store #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(in_code)),
      .wr_rec  (in_rec),
      .rd_en   (free1),
      .rd_addr (rd_addr),
      .rd_rec  (s1_rec)
   );

   gql_scale_stage u_scale (
      .clock  (clock),
      .en     (free2),
      .ctl    (s1_ctl_ff),
      .rec    (s1_rec),
      .steps  (steps_ff),
      .scaled (s2)
   );

   gql_pen_stage u_pen (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pen_ctl),
      .scaled   (s2),
      .origin_x (origin_x_ff),
      .origin_y (origin_y_ff),
      .quad     (quad)
   );

   assign req_tready = free1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, quad.uv_bottom_flip, quad.uv_top_flip, quad.uv_right,
                        quad.uv_left, quad.pos_bottom, quad.pos_top, quad.pos_right,
                        quad.pos_left};

`ifndef SYNTHESIS
   a_rsp_from_glyph: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(move2 && res2))
      else $error("response raised without a glyph leaving the last stage");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !free2 |=> v1_ff && $stable(s1_ctl_ff))
      else $error("first stage item lost while blocked");
`endif

endmodule

>>> sv/gql_glyph_store.sv
// ----------------------------------------------------------------------------
// gql_glyph_store
// glyph record memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gql_glyph_store #(
   parameter int GLYPH_COUNT = gql_pkg::GLYPH_COUNT_DEFAULT,
   localparam int ADDR_W = $clog2(GLYPH_COUNT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  gql_pkg::glyph_rec_type wr_rec,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output gql_pkg::glyph_rec_type rd_rec
);

   gql_pkg::glyph_rec_type glyph_ff [GLYPH_COUNT];
   gql_pkg::glyph_rec_type rd_data_ff;
   logic [GLYPH_COUNT-1:0] valid_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_ff[wr_addr] <= wr_rec;
      end
      if (rd_en) begin
         rd_data_ff <= glyph_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // entries not loaded since reset read as zero
   assign rd_rec = rd_valid_ff ? rd_data_ff : '0;

`ifndef SYNTHESIS
   a_unloaded_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rd_en && !valid_ff[rd_addr] |=> rd_rec == '0)
      else $error("unloaded glyph entry read as nonzero");
`endif

endmodule

>>> sv/gql_scale_stage.sv
// ----------------------------------------------------------------------------
// gql_scale_stage
// pixel counts times reciprocal steps, rounded to q.16 and registered
// ----------------------------------------------------------------------------
module gql_scale_stage (
   input  logic                   clock,
   input  logic                   en,
   input  gql_pkg::item_ctl_type  ctl,
   input  gql_pkg::glyph_rec_type rec,
   input  gql_pkg::step_cfg_type  steps,
   output gql_pkg::scaled_type    scaled
);

   logic signed [32:0] xs;
   logic signed [32:0] ys;
   logic signed [25:0] us;
   logic signed [25:0] vs;
   logic signed [8:0]  w9;
   logic signed [8:0]  h9;
   logic signed [8:0]  adv9;
   logic signed [8:0]  ch9;
   logic signed [12:0] ax13;
   logic signed [12:0] ay13;
   logic signed [10:0] offt;
   logic signed [10:0] ymul;

   logic signed [40:0] bx_p;
   logic signed [41:0] w_p;
   logic signed [43:0] y_p;
   logic signed [41:0] h_p;
   logic signed [41:0] adv_p;
   logic signed [38:0] ul_p;
   logic signed [34:0] uw_p;
   logic signed [38:0] vt_p;
   logic signed [34:0] vh_p;

   gql_pkg::scaled_type scaled_in;
   gql_pkg::scaled_type scaled_ff;

   always_comb begin
      xs   = $signed({1'b0, steps.x_step});
      ys   = $signed({1'b0, steps.y_step});
      us   = $signed({1'b0, steps.tex_u_step});
      vs   = $signed({1'b0, steps.tex_v_step});
      w9   = $signed({1'b0, rec.glyph_w});
      h9   = $signed({1'b0, rec.glyph_h});
      adv9 = $signed({1'b0, rec.advance_w});
      ch9  = $signed({1'b0, rec.cell_h});
      ax13 = $signed({1'b0, rec.atlas_x});
      ay13 = $signed({1'b0, rec.atlas_y});

      // top offset inside the cell, newline reuses the multiplier for line height
      offt = 11'(ch9) - 11'(rec.bearing_y) - 11'(h9);
      ymul = (ctl.kind == gql_pkg::KIND_NEWLINE) ? 11'(ch9) : offt;

      bx_p  = rec.bearing_x * xs;
      w_p   = w9 * xs;
      y_p   = ymul * ys;
      h_p   = h9 * ys;
      adv_p = adv9 * xs;
      ul_p  = ax13 * us;
      uw_p  = w9 * us;
      vt_p  = ay13 * vs;
      vh_p  = h9 * vs;

      scaled_in.ctl      = ctl;
      scaled_in.bear_x   = gql_pkg::round_step(gql_pkg::PROD_W'(bx_p));
      scaled_in.width_x  = gql_pkg::round_step(gql_pkg::PROD_W'(w_p));
      scaled_in.off_y    = gql_pkg::round_step(gql_pkg::PROD_W'(y_p));
      scaled_in.height_y = gql_pkg::round_step(gql_pkg::PROD_W'(h_p));
      scaled_in.adv_x    = gql_pkg::round_step(gql_pkg::PROD_W'(adv_p));
      scaled_in.u_left   = gql_pkg::round_step(gql_pkg::PROD_W'(ul_p));
      scaled_in.u_width  = gql_pkg::round_step(gql_pkg::PROD_W'(uw_p));
      scaled_in.v_top    = gql_pkg::round_step(gql_pkg::PROD_W'(vt_p));
      scaled_in.v_height = gql_pkg::round_step(gql_pkg::PROD_W'(vh_p));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

>>> sv/gql_pen_stage.sv
// ----------------------------------------------------------------------------
// gql_pen_stage
// pen position state, quad edge sums with saturation and result register
// ----------------------------------------------------------------------------
module gql_pen_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  gql_pkg::pen_ctl_type             ctl,
   input  gql_pkg::scaled_type              scaled,
   input  logic signed [gql_pkg::COORD_W-1:0] origin_x,
   input  logic signed [gql_pkg::COORD_W-1:0] origin_y,
   output gql_pkg::quad_type                quad
);

   logic signed [gql_pkg::COORD_W-1:0] pen_x_ff;
   logic signed [gql_pkg::COORD_W-1:0] pen_y_ff;
   logic signed [gql_pkg::COORD_W-1:0] pen_x_in;
   logic signed [gql_pkg::COORD_W-1:0] pen_y_in;
   logic signed [gql_pkg::COORD_W-1:0] pen_x_cur;
   logic signed [gql_pkg::COORD_W-1:0] pen_y_cur;

   logic signed [gql_pkg::SUM_W-1:0] left_sum;
   logic signed [gql_pkg::SUM_W-1:0] right_sum;
   logic signed [gql_pkg::SUM_W-1:0] top_sum;
   logic signed [gql_pkg::SUM_W-1:0] bottom_sum;
   logic signed [gql_pkg::SUM_W-1:0] ur_sum;
   logic signed [gql_pkg::SUM_W-1:0] vb_sum;

   gql_pkg::quad_type quad_in;
   gql_pkg::quad_type quad_ff;

   always_comb begin
      // start of text puts the pen back to the origin first
      pen_x_cur = scaled.ctl.start ? origin_x : pen_x_ff;
      pen_y_cur = scaled.ctl.start ? origin_y : pen_y_ff;

      left_sum   = gql_pkg::SUM_W'(pen_x_cur) + gql_pkg::SUM_W'(scaled.bear_x);
      right_sum  = left_sum + gql_pkg::SUM_W'(scaled.width_x);
      top_sum    = gql_pkg::SUM_W'(pen_y_cur) + gql_pkg::SUM_W'(scaled.off_y);
      bottom_sum = top_sum + gql_pkg::SUM_W'(scaled.height_y);
      ur_sum     = gql_pkg::SUM_W'(scaled.u_left) + gql_pkg::SUM_W'(scaled.u_width);
      vb_sum     = gql_pkg::SUM_W'(scaled.v_top) + gql_pkg::SUM_W'(scaled.v_height);

      quad_in.pos_left       = gql_pkg::sat_coord(left_sum);
      quad_in.pos_right      = gql_pkg::sat_coord(right_sum);
      quad_in.pos_top        = gql_pkg::sat_coord(top_sum);
      quad_in.pos_bottom     = gql_pkg::sat_coord(bottom_sum);
      quad_in.uv_left        = gql_pkg::sat_uv(gql_pkg::SUM_W'(scaled.u_left));
      quad_in.uv_right       = gql_pkg::sat_uv(ur_sum);
      quad_in.uv_top_flip    = gql_pkg::sat_uv(gql_pkg::UV_ONE - gql_pkg::SUM_W'(scaled.v_top));
      quad_in.uv_bottom_flip = gql_pkg::sat_uv(gql_pkg::UV_ONE - vb_sum);

      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      case (scaled.ctl.kind) inside
         gql_pkg::KIND_NEWLINE: begin
            pen_x_in = origin_x;
            pen_y_in = gql_pkg::sat_coord(gql_pkg::SUM_W'(pen_y_cur)
                                          - gql_pkg::SUM_W'(scaled.off_y));
         end
         gql_pkg::KIND_SPACE, gql_pkg::KIND_GLYPH: begin
            pen_x_in = gql_pkg::sat_coord(gql_pkg::SUM_W'(pen_x_cur)
                                          + gql_pkg::SUM_W'(scaled.adv_x));
            pen_y_in = pen_y_cur;
         end
         default: begin
            pen_x_in = pen_x_ff;
            pen_y_in = pen_y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else if (ctl.advance) begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         quad_ff <= quad_in;
      end
   end

   assign quad = quad_ff;

`ifndef SYNTHESIS
   a_newline_returns_x: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && scaled.ctl.kind == gql_pkg::KIND_NEWLINE
      |=> pen_x_ff == $past(origin_x))
      else $error("newline did not return pen x to origin");

   a_quad_ordered: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> ($signed(quad_ff.pos_right) >= $signed(quad_ff.pos_left))
                   && ($signed(quad_ff.pos_bottom) >= $signed(quad_ff.pos_top))
                   && (quad_ff.uv_right >= quad_ff.uv_left)
                   && (quad_ff.uv_bottom_flip <= quad_ff.uv_top_flip))
      else $error("quad edges out of order");
`endif

endmodule

>>> tb/sv/glyph_quad_layout_core_tb.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_core_tb
// self-checking bench: a glyph table and pen model predicts every quad from
// the accepted request transactions; directed corner items first, then
// random text runs under several step and origin settings, with random
// idle cycles on the request side and random stalls on the response side
// ----------------------------------------------------------------------------
module glyph_quad_layout_core_tb;

   localparam int GLYPHS       = gql_pkg::GLYPH_COUNT_DEFAULT;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 105;

   localparam logic [2:0] REG_X_STEP     = 3'd0;
   localparam logic [2:0] REG_Y_STEP     = 3'd1;
   localparam logic [2:0] REG_TEX_U_STEP = 3'd2;
   localparam logic [2:0] REG_TEX_V_STEP = 3'd3;
   localparam logic [2:0] REG_ORIGIN_X   = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd5;

   localparam logic       OP_PLACE    = 1'b1;
   localparam logic [7:0] CH_UPPER_A  = 8'd65;
   localparam logic [7:0] CH_UPPER_Z  = 8'd90;
   localparam logic [7:0] LAST_GLYPH  = 8'(GLYPHS - 1);
   localparam logic [7:0] FIRST_EXTRA = 8'(GLYPHS);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   int unsigned cycle_count = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;

   glyph_quad_layout_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   class glyph_typesetter;
      gql_pkg::glyph_rec_type glyphs[GLYPHS];
      longint                 pen_x, pen_y, origin_x, origin_y;
      logic [31:0]            x_step, y_step;
      logic [24:0]            u_step, v_step;
      gql_pkg::quad_type      quads_due[$];
      int                     mismatches;
      string                  field_names[8] = '{"pos_left", "pos_right", "pos_top",
                                                 "pos_bottom", "uv_left", "uv_right",
                                                 "uv_top_flip", "uv_bottom_flip"};

      function new();
         foreach (glyphs[i]) glyphs[i] = '0;
         pen_x = 0;
         pen_y = 0;
         origin_x = 0;
         origin_y = 0;
         x_step = '0;
         y_step = '0;
         u_step = '0;
         v_step = '0;
         mismatches = 0;
      endfunction

      // pixels times a q.24 step, back to q.16 with round half up
      function longint scale(longint pixels, longint step);
         return (pixels * step + 128) >>> 8;
      endfunction

      function longint clamp_coord(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function longint clamp_uv(longint v);
         if (v > 65536) return 65536;
         if (v < 0) return 0;
         return v;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_X_STEP:     x_step = val;
            REG_Y_STEP:     y_step = val;
            REG_TEX_U_STEP: u_step = val[24:0];
            REG_TEX_V_STEP: v_step = val[24:0];
            REG_ORIGIN_X:   origin_x = longint'($signed(val[23:0]));
            REG_ORIGIN_Y:   origin_y = longint'($signed(val[23:0]));
            default: ;
         endcase
      endfunction

      function void accept_item(logic op, logic [7:0] code, gql_pkg::glyph_rec_type rec,
                                logic start);
         gql_pkg::glyph_rec_type g;
         gql_pkg::quad_type      q;
         logic [6:0]             sel;
         longint                 xs, ys, us, vs, bx, by, gw, gh, ax, ay, adv, cell_px;
         longint                 l, r, t, b, ul, ur, vt, vb, offt;
         xs = longint'(x_step);
         ys = longint'(y_step);
         us = longint'(u_step);
         vs = longint'(v_step);
         if (op == gql_pkg::OP_LOAD) begin
            if (code < GLYPHS) glyphs[code[6:0]] = rec;
            return;
         end
         if (start) begin
            pen_x = origin_x;
            pen_y = origin_y;
         end
         if (code == gql_pkg::CH_NEWLINE) begin
            cell_px = longint'(glyphs[gql_pkg::CH_SPACE[6:0]].cell_h);
            pen_y = clamp_coord(pen_y - scale(cell_px, ys));
            pen_x = origin_x;
            return;
         end
         if (code == gql_pkg::CH_SPACE) begin
            adv = longint'(glyphs[gql_pkg::CH_SPACE[6:0]].advance_w);
            pen_x = clamp_coord(pen_x + scale(adv, xs));
            return;
         end
         sel = (code >= GLYPHS) ? gql_pkg::CH_QUESTION[6:0] : code[6:0];
         g = glyphs[sel];
         ax = longint'(g.atlas_x);
         ay = longint'(g.atlas_y);
         gw = longint'(g.glyph_w);
         gh = longint'(g.glyph_h);
         bx = longint'($signed(g.bearing_x));
         by = longint'($signed(g.bearing_y));
         adv = longint'(g.advance_w);
         cell_px = longint'(g.cell_h);

         ul = scale(ax, us);
         ur = ul + scale(gw, us);
         vt = scale(ay, vs);
         vb = vt + scale(gh, vs);
         offt = cell_px - by - gh;
         l = pen_x + scale(bx, xs);
         r = l + scale(gw, xs);
         t = pen_y + scale(offt, ys);
         b = t + scale(gh, ys);

         q.pos_left       = 24'(clamp_coord(l));
         q.pos_right      = 24'(clamp_coord(r));
         q.pos_top        = 24'(clamp_coord(t));
         q.pos_bottom     = 24'(clamp_coord(b));
         q.uv_left        = 17'(clamp_uv(ul));
         q.uv_right       = 17'(clamp_uv(ur));
         q.uv_top_flip    = 17'(clamp_uv(65536 - vt));
         q.uv_bottom_flip = 17'(clamp_uv(65536 - vb));
         quads_due.push_back(q);

         pen_x = clamp_coord(pen_x + scale(adv, xs));
      endfunction

      function void check_quad(logic [167:0] d);
         gql_pkg::quad_type q;
         logic [23:0]       want[8];
         logic [23:0]       got[8];
         if (quads_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected quad: expected none, got %h", $time, d);
            return;
         end
         q = quads_due.pop_front();
         want = '{q.pos_left, q.pos_right, q.pos_top, q.pos_bottom, 24'(q.uv_left),
                  24'(q.uv_right), 24'(q.uv_top_flip), 24'(q.uv_bottom_flip)};
         got = '{d[23:0], d[47:24], d[71:48], d[95:72], 24'(d[112:96]), 24'(d[129:113]),
                 24'(d[146:130]), 24'(d[163:147])};
         for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i]) begin
               mismatches++;
               $display("%0t %s: expected %h, got %h", $time, field_names[i], want[i],
                        got[i]);
            end
         end
      endfunction
   endclass

   glyph_typesetter typesetter = new();

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[glyph_quad_layout_core] ERROR");
         $finish;
      end
   end

   function automatic int draw_wait(ref int calm);
      int w;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      w = $urandom_range(0, 11);
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 30);
      return w;
   endfunction

   function automatic gql_pkg::glyph_rec_type make_rec(int ax, int ay, int w, int h, int bx,
                                                       int by, int adv, int cell_px);
      gql_pkg::glyph_rec_type rec;
      rec.atlas_x   = 12'(ax);
      rec.atlas_y   = 12'(ay);
      rec.glyph_w   = 8'(w);
      rec.glyph_h   = 8'(h);
      rec.bearing_x = 8'(bx);
      rec.bearing_y = 8'(by);
      rec.advance_w = 8'(adv);
      rec.cell_h    = 8'(cell_px);
      return rec;
   endfunction

   function automatic gql_pkg::glyph_rec_type random_glyph(bit modest);
      if (modest && $urandom_range(0, 3) != 0) begin
         return make_rec($urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 24),
                         $urandom_range(0, 32), $urandom_range(0, 8) - 4,
                         $urandom_range(0, 24), $urandom_range(0, 24), $urandom_range(8, 40));
      end
      return gql_pkg::glyph_rec_type'(72'({$urandom, $urandom, $urandom}));
   endfunction

   task automatic send_item(logic op, logic [7:0] code, gql_pkg::glyph_rec_type rec,
                            logic start);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, start, rec.cell_h, rec.advance_w, rec.bearing_y, rec.bearing_x,
                     rec.glyph_h, rec.glyph_w, rec.atlas_y, rec.atlas_x, code};
      do @(posedge clock); while (!req_tready);
      typesetter.accept_item(op, code, rec, start);
   endtask

   task automatic place_char(logic [7:0] code, logic start);
      send_item(OP_PLACE, code, random_glyph(1'b0), start);
   endtask

   task automatic load_glyph(logic [7:0] code, gql_pkg::glyph_rec_type rec);
      send_item(gql_pkg::OP_LOAD, code, rec, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (typesetter.quads_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_layout(logic [31:0] xs, logic [31:0] ys, logic [31:0] us,
                             logic [31:0] vs, logic [31:0] ox, logic [31:0] oy);
      logic [31:0] vals[6];
      logic [2:0]  idx[6];
      vals = '{xs, ys, us, vs, ox, oy};
      idx  = '{REG_X_STEP, REG_Y_STEP, REG_TEX_U_STEP, REG_TEX_V_STEP, REG_ORIGIN_X,
               REG_ORIGIN_Y};
      wait_drained();
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         typesetter.write_reg(idx[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_text(int count, bit modest);
      int          pick;
      logic [7:0]  code;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            case ($urandom_range(0, 9))
               0: code = 8'($urandom_range(FIRST_EXTRA, 255));
               1: code = gql_pkg::CH_SPACE;
               2: code = gql_pkg::CH_QUESTION;
               3: code = 8'($urandom_range(0, LAST_GLYPH));
               default: code = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            endcase
            load_glyph(code, random_glyph(modest));
         end else begin
            case ($urandom_range(0, 19))
               0, 1:    code = gql_pkg::CH_NEWLINE;
               2, 3, 4: code = gql_pkg::CH_SPACE;
               5:       code = 8'($urandom_range(FIRST_EXTRA, 255));
               6:       code = 8'($urandom_range(0, 255));
               default: code = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            endcase
            place_char(code, $urandom_range(0, 15) == 0);
         end
      end
   endtask

   initial begin
      wait (!reset);
      forever begin
         int stall;
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         typesetter.check_quad(rsp_tdata);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unwritten glyphs at reset settings
      place_char(CH_UPPER_A, 1'b1);
      place_char(8'd200, 1'b0);
      place_char(gql_pkg::CH_NEWLINE, 1'b0);
      place_char(gql_pkg::CH_SPACE, 1'b0);

      set_layout(32'h0010_0000, 32'h0010_0000, 32'h0000_1000, 32'h0000_1000,
                 32'h00FF_0000, 32'h0001_0000);
      load_glyph(gql_pkg::CH_SPACE, make_rec(7, 9, 3, 5, 1, 2, 8, 16));
      load_glyph(gql_pkg::CH_QUESTION, make_rec(4095, 4095, 255, 255, -128, -128, 255, 255));
      load_glyph(CH_UPPER_A, make_rec(0, 0, 0, 0, 127, 127, 0, 0));
      load_glyph(8'd255, make_rec(4095, 4095, 255, 255, 127, 127, 255, 255));
      load_glyph(LAST_GLYPH, random_glyph(1'b1));
      load_glyph(8'd0, random_glyph(1'b1));
      place_char(CH_UPPER_A, 1'b1);
      place_char(gql_pkg::CH_SPACE, 1'b0);
      place_char(gql_pkg::CH_QUESTION, 1'b0);
      place_char(gql_pkg::CH_NEWLINE, 1'b0);
      place_char(8'd255, 1'b0);
      place_char(FIRST_EXTRA, 1'b0);
      place_char(LAST_GLYPH, 1'b0);
      place_char(8'd0, 1'b0);
      place_char(gql_pkg::CH_NEWLINE, 1'b1);
      place_char(gql_pkg::CH_SPACE, 1'b1);
      send_item(gql_pkg::OP_LOAD, CH_UPPER_A, make_rec(100, 200, 10, 12, -2, 9, 11, 14), 1'b1);
      place_char(CH_UPPER_A, 1'b0);

      // plausible screen and atlas scaling
      set_layout(32'd41943, 32'd55924, 32'd32768, 32'd65536,
                 {8'($urandom), 24'hFF_0000}, 32'h0001_0000);
      random_text(PHASE_ITEMS, 1'b1);

      // largest position steps and origins, saturation everywhere
      set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16777216, 32'd16777216,
                 32'h007F_FFFF, 32'h007F_FFFF);
      random_text(PHASE_ITEMS, 1'b0);

      // zero steps, most negative origin
      set_layout(32'd0, 32'd0, 32'd0, 32'd0, 32'h0080_0000, 32'hFF80_0000);
      random_text(PHASE_ITEMS, 1'b0);

      // texture steps above one with junk in the unused bits
      set_layout($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22),
                 32'hFE00_0000 | 32'h01FF_FFFF, {7'($urandom), 25'h1FF_FFFF},
                 $urandom, $urandom);
      random_text(PHASE_ITEMS, 1'b0);

      set_layout($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_text(PHASE_ITEMS, 1'b1);

      set_layout($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                 $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16),
                 $urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF));
      random_text(PHASE_ITEMS, 1'b1);

      wait_drained();
      if (typesetter.mismatches == 0 && typesetter.quads_due.size() == 0) begin
         $display("[glyph_quad_layout_core] OK");
      end else begin
         $display("[glyph_quad_layout_core] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
sv/gql_pkg.sv
sv/gql_glyph_store.sv
sv/gql_scale_stage.sv
sv/gql_pen_stage.sv
sv/glyph_quad_layout_core.sv
tb/sv/glyph_quad_layout_core_tb.sv
